// File: sv/apcs_pkg.sv
package apcs_pkg;

   localparam int WORD_BITS   = 16;
   localparam int SLOT_W      = 5;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0]  ATTEN_MAX = 8'd89;
   localparam logic [7:0]  SEL_MAX   = 8'd3;
   localparam logic [7:0]  GAIN_MAX  = 8'd6;
   localparam logic [15:0] MUTE_WORD = 16'hFFFE;

   typedef enum logic [1:0] {
      FUNC_VOLUME = 2'd0,
      FUNC_INPUT  = 2'd1,
      FUNC_TONE   = 2'd2,
      FUNC_MUTE   = 2'd3
   } func_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // clamp a signed attenuation to 0..89
   function automatic logic [6:0] clamp_atten(input logic signed [7:0] v);
      logic [6:0] r;
      if (v[7]) begin
         r = 7'd0;
      end else if (v > $signed(ATTEN_MAX)) begin
         r = ATTEN_MAX[6:0];
      end else begin
         r = v[6:0];
      end
      return r;
   endfunction

   // saturate to -15..15, then sign-magnitude with bit 4 marking positive
   function automatic logic [4:0] sign_mag(input logic signed [4:0] v);
      logic [4:0] r;
      logic [4:0] neg;
      neg = -v;
      if (v == 5'sb10000) begin
         r = 5'd15;
      end else if (!v[4] && (v != 5'sd0)) begin
         r = {1'b1, v[3:0]};
      end else begin
         r = {1'b0, neg[3:0]};
      end
      return r;
   endfunction

endpackage

// File: sv/apcs_front.sv
module apcs_front
   import apcs_pkg::*;
(
   input  logic [1:0]           func,
   input  logic signed [7:0]    left_attenuation,
   input  logic signed [7:0]    right_attenuation,
   input  logic [7:0]           input_select,
   input  logic [7:0]           input_gain,
   input  logic                 tone_enable,
   input  logic signed [4:0]    bass_level,
   input  logic signed [4:0]    treble_level,
   output logic [WORD_BITS-1:0] word
);

   logic [6:0] left_c;
   logic [6:0] right_c;
   logic [1:0] sel_c;
   logic [2:0] gain_c;
   logic [4:0] bass_sm;
   logic [4:0] treble_sm;

   always_comb begin
      left_c    = clamp_atten(left_attenuation);
      right_c   = clamp_atten(right_attenuation);
      sel_c     = (input_select > SEL_MAX) ? SEL_MAX[1:0] : input_select[1:0];
      gain_c    = (input_gain > GAIN_MAX) ? GAIN_MAX[2:0] : input_gain[2:0];
      bass_sm   = sign_mag(bass_level);
      treble_sm = sign_mag(treble_level);
   end

   always_comb begin
      unique case (func_type'(func))
         FUNC_VOLUME: begin
            word = {right_c, left_c, 2'b10};
         end
         FUNC_INPUT: begin
            word = {1'b0, sel_c, gain_c, tone_enable, 9'd0};
         end
         FUNC_TONE: begin
            word = {bass_sm, treble_sm, 5'd0, 1'b1};
         end
         FUNC_MUTE: begin
            word = MUTE_WORD;
         end
         default: begin
            word = MUTE_WORD;
         end
      endcase
   end

endmodule

// File: sv/apcs_queue.sv
module apcs_queue
   import apcs_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WORD_BITS-1:0]    push_word,
   input  logic                    pop,
   output logic [WORD_BITS-1:0]    pop_word,
   output queue_status_type        status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WORD_BITS-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_in;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);
   assign pop_word     = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// File: sv/apcs_back.sv
module apcs_back
   import apcs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  queue_status_type     q_status,
   input  logic [WORD_BITS-1:0] q_word,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_BITS-1:0] rsp_command_word,
   output logic                 rsp_data_at_rise,
   output logic                 rsp_data_at_fall,
   output logic                 rsp_latch_slot,
   output logic                 rsp_last
);

   localparam logic [SLOT_W-1:0] LATCH_SLOT = SLOT_W'(WORD_BITS);
   localparam logic [SLOT_W-1:0] FINAL_BIT  = SLOT_W'(WORD_BITS - 1);

   logic                 busy_ff;
   logic                 busy_in;
   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;
   logic [SLOT_W-1:0]    slot_ff;
   logic [SLOT_W-1:0]    slot_in;
   logic                 advance;
   logic                 at_latch;
   logic [3:0]           bit_idx;

   assign at_latch = (slot_ff == LATCH_SLOT);
   assign advance  = busy_ff && !rsp_stall;
   assign q_pop    = !q_status.empty && (!busy_ff || (advance && at_latch));
   assign bit_idx  = 4'(FINAL_BIT - slot_ff);

   always_comb begin
      busy_in = busy_ff;
      word_in = word_ff;
      slot_in = slot_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         word_in = q_word;
         slot_in = '0;
      end else if (advance) begin
         if (at_latch) begin
            busy_in = 1'b0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         slot_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rsp_valid        = busy_ff;
   assign rsp_command_word = word_ff;
   assign rsp_data_at_rise = !at_latch && word_ff[bit_idx];
   assign rsp_data_at_fall = (slot_ff == FINAL_BIT);
   assign rsp_latch_slot   = at_latch;
   assign rsp_last         = at_latch;

endmodule

// File: sv/audio_processor_command_serializer_unit.sv
// channel   direction  payload
// req_      in         func, attenuations, input select/gain, tone enable, bass, treble
// rsp_      out        command word, data at rise/fall, latch slot, last
//
// Each request yields 17 responses: 16 bit slots MSB first, then one latch slot.
// Words go out back to back, paced by the back end slot counter and by rsp_stall.
// A request is accepted whenever the word queue has room, also while responses stall.
// Reset is synchronous and empties the queue and the serializer.
module audio_processor_command_serializer_unit
   import apcs_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_func,
   input  logic signed [7:0]    req_left_attenuation,
   input  logic signed [7:0]    req_right_attenuation,
   input  logic [7:0]           req_input_select,
   input  logic [7:0]           req_input_gain,
   input  logic                 req_tone_enable,
   input  logic signed [4:0]    req_bass_level,
   input  logic signed [4:0]    req_treble_level,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_BITS-1:0] rsp_command_word,
   output logic                 rsp_data_at_rise,
   output logic                 rsp_data_at_fall,
   output logic                 rsp_latch_slot,
   output logic                 rsp_last
);

   logic [WORD_BITS-1:0] front_word;
   logic [WORD_BITS-1:0] q_word;
   logic                 q_pop;
   logic                 q_push;
   queue_status_type     q_status;

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

   apcs_front u_front (
      .func              (req_func),
      .left_attenuation  (req_left_attenuation),
      .right_attenuation (req_right_attenuation),
      .input_select      (req_input_select),
      .input_gain        (req_input_gain),
      .tone_enable       (req_tone_enable),
      .bass_level        (req_bass_level),
      .treble_level      (req_treble_level),
      .word              (front_word)
   );

   apcs_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (front_word),
      .pop       (q_pop),
      .pop_word  (q_word),
      .status    (q_status)
   );

   apcs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_word           (q_word),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command_word (rsp_command_word),
      .rsp_data_at_rise (rsp_data_at_rise),
      .rsp_data_at_fall (rsp_data_at_fall),
      .rsp_latch_slot   (rsp_latch_slot),
      .rsp_last         (rsp_last)
   );

endmodule
